[src/sma_pkg.sv]
// Package for the moving-average unit: widths, window limits and reset value.
// No dependencies; imported by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

  localparam int unsigned WINDOW_MAX = 1024;
  localparam int unsigned PTR_W      = $clog2(WINDOW_MAX);
  localparam int unsigned LEN_W      = PTR_W + 1;
  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned STAMP_W    = 48;
  localparam int unsigned SUM_W      = PRICE_W + PTR_W;
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);
  localparam int unsigned REM_W      = LEN_W + 1;

  localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(20);

endpackage

`default_nettype wire

[src/sma_if.sv]
// Request and result channel interfaces of the moving-average unit.
// Depends on sma_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface sma_in_if import sma_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PRICE_W-1:0] close_price;
  logic        [STAMP_W-1:0] timestamp;
  logic                      restart;
  logic                      last_in_batch;

  modport source (
    output valid, close_price, timestamp, restart, last_in_batch,
    input  ready
  );
  modport sink (
    input  valid, close_price, timestamp, restart, last_in_batch,
    output ready
  );
endinterface

interface sma_out_if import sma_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PRICE_W-1:0] average;
  logic                      average_valid;
  logic        [STAMP_W-1:0] stamp_out;
  logic                      batch_end;

  modport source (
    output valid, average, average_valid, stamp_out, batch_end,
    input  ready
  );
  modport sink (
    input  valid, average, average_valid, stamp_out, batch_end,
    output ready
  );
endinterface

`default_nettype wire

[src/simple_moving_average_unit.sv]
// Moving-average unit: from acceptance until the next request can be taken,
// each request passes through one ring read, one sum update, 42 bit-serial
// divide steps by the window length and one output load, after which the
// result sits in the output register. Samples live in a 1024 x 32
// single-port-read ring memory; a new request is taken while the previous
// result still waits in the output register. Results are valid once
// window_length samples have been seen since reset, a restart, or a
// window_length write. Depends on sma_pkg and sma_if.
`timescale 1ns / 1ps
`default_nettype none

module simple_moving_average_unit import sma_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  sma_in_if.sink                req_i,
  sma_out_if.source             res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [LEN_W-1:0]         window_q;
  logic [LEN_W-1:0]         len_eff;
  logic signed [SUM_W-1:0]  sum_q;
  logic [PTR_W-1:0]         wp_q;
  logic [LEN_W-1:0]         seen_q;

  logic [PRICE_W-1:0]       price_q;
  logic [STAMP_W-1:0]       stamp_q;
  logic                     restart_q;
  logic                     last_q;

  logic [PRICE_W-1:0]       ring_mem [WINDOW_MAX];
  logic [PRICE_W-1:0]       rdata_q;
  logic [PTR_W-1:0]         rd_addr;

  logic signed [SUM_W-1:0]  sum_base;
  logic [PTR_W-1:0]         wp_base;
  logic [LEN_W-1:0]         seen_base;
  logic                     full;
  logic signed [SUM_W-1:0]  sum_d;
  logic [LEN_W-1:0]         seen_next;
  logic [SUM_W-1:0]         sum_abs;

  logic [SUM_W-1:0]         quo_q;
  logic [REM_W-1:0]         rem_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     neg_q;
  logic [REM_W-1:0]         rem_sh;
  logic                     q_bit;
  logic [PRICE_W-1:0]       q_lo;

  logic                     out_valid_q;
  logic signed [PRICE_W-1:0] avg_q;
  logic                     avg_valid_q;
  logic [STAMP_W-1:0]       stamp_out_q;
  logic                     batch_end_q;
  logic                     out_load;
  logic                     req_fire;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    priority if (window_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (window_q > LEN_W'(WINDOW_MAX)) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = window_q;
    end
  end

  // restart applies before the sample is taken in
  assign sum_base  = restart_q ? '0 : sum_q;
  assign wp_base   = restart_q ? '0 : wp_q;
  assign seen_base = restart_q ? '0 : seen_q;
  assign full      = (seen_base >= len_eff);
  assign rd_addr   = wp_base - len_eff[PTR_W-1:0];

  always_comb begin
    sum_d = sum_base + SUM_W'(signed'(price_q));
    if (full) begin
      sum_d = sum_d - SUM_W'(signed'(rdata_q));
    end
    seen_next = full ? seen_base : seen_base + LEN_W'(1);
    sum_abs   = sum_d[SUM_W-1] ? (~sum_d + SUM_W'(1)) : sum_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      rdata_q <= ring_mem[rd_addr];
    end
    if (state_q == S_SUM) begin
      ring_mem[wp_base] <= price_q;
    end
  end

  // restoring divide, one quotient bit per cycle
  assign rem_sh = {rem_q[REM_W-2:0], quo_q[SUM_W-1]};
  assign q_bit  = (rem_sh >= REM_W'(len_eff));
  assign q_lo   = quo_q[PRICE_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req_fire) state_d = S_RD;
      S_RD:    state_d = S_SUM;
      S_SUM:   state_d = S_DIV;
      S_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_DONE;
      S_DONE:  if (!out_valid_q || res_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= WINDOW_RESET;
      sum_q       <= '0;
      wp_q        <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
        sum_q    <= '0;
        wp_q     <= '0;
        seen_q   <= '0;
      end else if (state_q == S_SUM) begin
        sum_q  <= sum_d;
        wp_q   <= wp_base + PTR_W'(1);
        seen_q <= seen_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      price_q   <= req_i.close_price;
      stamp_q   <= req_i.timestamp;
      restart_q <= req_i.restart;
      last_q    <= req_i.last_in_batch;
    end
    if (state_q == S_SUM) begin
      quo_q <= sum_abs;
      rem_q <= '0;
      cnt_q <= '0;
      neg_q <= sum_d[SUM_W-1];
    end else if (state_q == S_DIV) begin
      quo_q <= {quo_q[SUM_W-2:0], q_bit};
      rem_q <= q_bit ? rem_sh - REM_W'(len_eff) : rem_sh;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (out_load) begin
      avg_valid_q <= (seen_q >= len_eff);
      avg_q       <= (seen_q >= len_eff)
                     ? signed'(neg_q ? (~q_lo + PRICE_W'(1)) : q_lo) : '0;
      stamp_out_q <= stamp_q;
      batch_end_q <= last_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.average       = avg_q;
  assign res_o.average_valid = avg_valid_q;
  assign res_o.stamp_out     = stamp_out_q;
  assign res_o.batch_end     = batch_end_q;

`ifndef ASSERT_OFF
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= len_eff)
    else $error("sample count exceeds window length");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)))
    else $error("divide step count out of range");

  a_load_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !res_o.ready) |=> (state_q == S_DONE))
    else $error("result dropped while output register busy");
`endif

endmodule

`default_nettype wire
